// ===== src/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// stq_pkg
// shared types, codes and defaults for the sorted timer queue
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam int ID_BITS_DEF = 16;
  localparam int MAX_RES     = 16;
  localparam int CMD_W       = 3;
  localparam int DELAY_W     = 31;
  localparam int KIND_W      = 3;
  localparam int TIME_W      = 32;
  localparam int RES_W       = $clog2(MAX_RES + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_ADD_ONE = 3'd1,
    CMD_ADD_PER = 3'd2,
    CMD_REMOVE  = 3'd3,
    CMD_QUERY   = 3'd4
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    K_ADDED     = 3'd0,
    K_EXPIRED   = 3'd1,
    K_REMAINING = 3'd2,
    K_NOT_FOUND = 3'd3,
    K_FULL      = 3'd4,
    K_REMOVED   = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_INS,
    ST_SRCH,
    ST_EXP_CHK,
    ST_EXP_EMIT,
    ST_EXP_POP,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_TICK,
    OP_ADD_SETUP,
    OP_INS_STEP,
    OP_SRCH_SETUP,
    OP_SRCH_STEP,
    OP_EXP_POP
  } op_t;

  typedef struct packed {
    op_t   op;
    logic  out_load;
    kind_t out_kind;
    logic  out_last;
  } ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             exp_more;
    logic             n_zero;
    logic             head_per_nz;
    logic             ins_done;
    logic             srch_done;
    logic             found;
    logic             out_busy;
  } sts_t;

endpackage

// ===== src/stq_in_if.sv =====
// ----------------------------------------------------------------------------
// stq_in_if
// command channel: valid, ready and one command beat
// ----------------------------------------------------------------------------
interface stq_in_if
  import stq_pkg::*;
#(
  parameter int ID_BITS = ID_BITS_DEF
);
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [DELAY_W-1:0] delay_ms;
  logic [ID_BITS-1:0] tid;

  modport source (output valid, cmd, delay_ms, tid, input ready);
  modport sink   (input valid, cmd, delay_ms, tid, output ready);
endinterface

// ===== src/stq_out_if.sv =====
// ----------------------------------------------------------------------------
// stq_out_if
// result channel: valid, ready and one result beat
// ----------------------------------------------------------------------------
interface stq_out_if
  import stq_pkg::*;
#(
  parameter int ID_BITS = ID_BITS_DEF
);
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [ID_BITS-1:0] result_id;
  logic [DELAY_W-1:0] remaining_ms;
  logic               last;

  modport source (output valid, kind, result_id, remaining_ms, last, input ready);
  modport sink   (input valid, kind, result_id, remaining_ms, last, output ready);
endinterface

// ===== src/sorted_timer_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_timer_queue
// up to DEPTH millisecond timers kept in trigger order, with add, remove,
// query and tick commands
// ----------------------------------------------------------------------------
// Takes one command at a time. The entries sit in a register queue that can
// rotate its head to the tail, pop its head or push at its tail; every walk
// goes over the live entries one per cycle, so the count of live entries sets
// the cost. A sorted add, a remove and a query each walk the queue once; an
// add to a full queue is answered without a walk. A tick takes each due timer
// in turn and walks the queue again for each one that re-arms. Results leave
// through a one-beat output register; the block waits while it is still full.
// Up to MAX_RES timers expire per tick; the rest stay due at the head.
module sorted_timer_queue
  import stq_pkg::*;
#(
  parameter int DEPTH   = DEPTH_DEF,
  parameter int ID_BITS = ID_BITS_DEF
)(
  input  logic clk,
  input  logic rst_n,
  stq_in_if.sink    in_ch,
  stq_out_if.source out_ch
);

  ctl_t ctl;   // controller commands to the datapath
  sts_t sts;   // datapath status back to the controller

  // sequencer: walks, expiry run, result emission
  stq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // entry queue, time base, id counter and output register
  stq_dp #(
    .DEPTH   (DEPTH),
    .ID_BITS (ID_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_cmd           (in_ch.cmd),
    .in_delay_ms      (in_ch.delay_ms),
    .in_tid           (in_ch.tid),
    .ctl              (ctl),
    .sts              (sts),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_kind         (out_ch.kind),
    .out_result_id    (out_ch.result_id),
    .out_remaining_ms (out_ch.remaining_ms),
    .out_last         (out_ch.last)
  );

endmodule

// ===== src/stq_ctrl.sv =====
// ----------------------------------------------------------------------------
// stq_ctrl
// sequencer for insert walks, id searches and the expiry run
// ----------------------------------------------------------------------------
module stq_ctrl
  import stq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output ctl_t ctl
);

  state_t state_r, state_nxt;
  kind_t  fin_kind_r, fin_kind_nxt;
  logic   ins_tick_r, ins_tick_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      fin_kind_r <= K_ADDED;
      ins_tick_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fin_kind_r <= fin_kind_nxt;
      ins_tick_r <= ins_tick_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    fin_kind_nxt = fin_kind_r;
    ins_tick_nxt = ins_tick_r;
    in_ready     = 1'b0;
    ctl.op       = OP_NONE;
    ctl.out_load = 1'b0;
    ctl.out_kind = K_EXPIRED;
    ctl.out_last = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.op    = OP_LOAD;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts.cmd)
          CMD_TICK: begin
            ctl.op       = OP_TICK;
            ins_tick_nxt = 1'b1;
            state_nxt    = ST_EXP_CHK;
          end
          CMD_ADD_ONE, CMD_ADD_PER: begin
            if (sts.full) begin
              fin_kind_nxt = K_FULL;
              state_nxt    = ST_FIN;
            end else begin
              ctl.op       = OP_ADD_SETUP;
              ins_tick_nxt = 1'b0;
              state_nxt    = ST_INS;
            end
          end
          CMD_REMOVE, CMD_QUERY: begin
            ctl.op    = OP_SRCH_SETUP;
            state_nxt = ST_SRCH;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_INS: begin
        if (sts.ins_done) begin
          if (ins_tick_r) begin
            state_nxt = ST_EXP_CHK;
          end else begin
            fin_kind_nxt = K_ADDED;
            state_nxt    = ST_FIN;
          end
        end else begin
          ctl.op = OP_INS_STEP;
        end
      end
      ST_SRCH: begin
        if (sts.srch_done) begin
          if (!sts.found) begin
            fin_kind_nxt = K_NOT_FOUND;
          end else if (sts.cmd == CMD_REMOVE) begin
            fin_kind_nxt = K_REMOVED;
          end else begin
            fin_kind_nxt = K_REMAINING;
          end
          state_nxt = ST_FIN;
        end else begin
          ctl.op = OP_SRCH_STEP;
        end
      end
      ST_EXP_CHK: begin
        if (sts.exp_more) begin
          state_nxt = sts.n_zero ? ST_EXP_POP : ST_EXP_EMIT;
        end else if (!sts.n_zero) begin
          fin_kind_nxt = K_EXPIRED;
          state_nxt    = ST_FIN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EXP_EMIT: begin
        if (!sts.out_busy) begin
          ctl.out_load = 1'b1;
          ctl.out_kind = K_EXPIRED;
          state_nxt    = ST_EXP_POP;
        end
      end
      ST_EXP_POP: begin
        ctl.op    = OP_EXP_POP;
        state_nxt = sts.head_per_nz ? ST_INS : ST_EXP_CHK;
      end
      ST_FIN: begin
        if (!sts.out_busy) begin
          ctl.out_load = 1'b1;
          ctl.out_kind = fin_kind_r;
          ctl.out_last = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== src/stq_dp.sv =====
// ----------------------------------------------------------------------------
// stq_dp
// entry queue with head rotate, pop and tail push, time and id registers
// ----------------------------------------------------------------------------
module stq_dp
  import stq_pkg::*;
#(
  parameter int DEPTH   = DEPTH_DEF,
  parameter int ID_BITS = ID_BITS_DEF
)(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [CMD_W-1:0]   in_cmd,
  input  logic [DELAY_W-1:0] in_delay_ms,
  input  logic [ID_BITS-1:0] in_tid,
  input  ctl_t               ctl,
  output sts_t               sts,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [KIND_W-1:0]  out_kind,
  output logic [ID_BITS-1:0] out_result_id,
  output logic [DELAY_W-1:0] out_remaining_ms,
  output logic               out_last
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [TIME_W-1:0] MSB = {1'b1, {(TIME_W-1){1'b0}}};

  logic [TIME_W-1:0]  trig_r [DEPTH];
  logic [DELAY_W-1:0] per_r  [DEPTH];
  logic [ID_BITS-1:0] ids_r  [DEPTH];

  logic [CNT_W-1:0]   cnt_r, k_r;
  logic [TIME_W-1:0]  now_r;
  logic [ID_BITS-1:0] next_id_r;
  logic [RES_W-1:0]   n_r;
  logic               done_r, found_r;
  logic [CMD_W-1:0]   cmd_r;
  logic [DELAY_W-1:0] delay_r, rem_r;
  logic [ID_BITS-1:0] tid_r, pend_id_r;
  logic [TIME_W-1:0]  new_trig_r;
  logic [DELAY_W-1:0] new_per_r;
  logic [ID_BITS-1:0] new_id_r;
  logic               out_valid_r, out_last_r;
  logic [KIND_W-1:0]  out_kind_r;
  logic [ID_BITS-1:0] out_id_r;
  logic [DELAY_W-1:0] out_rem_r;

  logic [TIME_W-1:0]  head_diff, new_diff;
  logic [DELAY_W-1:0] head_rem;
  logic               head_ge, head_due, match;
  logic               rot_en, pop_en, push_en;
  logic [ID_BITS-1:0] gen_id;

  assign head_diff = trig_r[0] - now_r;
  assign new_diff  = new_trig_r - now_r;
  // signed order of distance to now
  assign head_ge   = (head_diff ^ MSB) >= (new_diff ^ MSB);
  assign head_due  = head_diff[TIME_W-1] || (head_diff == '0);
  assign head_rem  = head_diff[TIME_W-1] ? '0 : head_diff[DELAY_W-1:0];
  assign match     = (ids_r[0] == tid_r) && !found_r;
  assign gen_id    = ((next_id_r + 1'b1) == '0) ? ID_BITS'(1) : next_id_r + 1'b1;

  always_comb begin
    rot_en  = 1'b0;
    pop_en  = 1'b0;
    push_en = 1'b0;
    case (ctl.op)
      OP_INS_STEP: begin
        if (!done_r && ((k_r == '0) || head_ge)) push_en = 1'b1;
        else if (k_r != '0)                       rot_en  = 1'b1;
      end
      OP_SRCH_STEP: begin
        if (match && (cmd_r == CMD_REMOVE)) pop_en = 1'b1;
        else                                rot_en = 1'b1;
      end
      OP_EXP_POP: pop_en = 1'b1;
      default: ;
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_ent
    always_ff @(posedge clk) begin
      if (i < DEPTH - 1) begin
        if ((rot_en || pop_en) && (CNT_W'(i + 1) < cnt_r)) begin
          trig_r[i] <= trig_r[(i + 1) % DEPTH];
          per_r[i]  <= per_r[(i + 1) % DEPTH];
          ids_r[i]  <= ids_r[(i + 1) % DEPTH];
        end
      end
      if (rot_en && (CNT_W'(i + 1) == cnt_r)) begin
        trig_r[i] <= trig_r[0];
        per_r[i]  <= per_r[0];
        ids_r[i]  <= ids_r[0];
      end
      if (push_en && (CNT_W'(i) == cnt_r)) begin
        trig_r[i] <= new_trig_r;
        per_r[i]  <= new_per_r;
        ids_r[i]  <= new_id_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      k_r         <= '0;
      now_r       <= '0;
      next_id_r   <= '0;
      n_r         <= '0;
      done_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (push_en) cnt_r <= cnt_r + 1'b1;
      if (pop_en)  cnt_r <= cnt_r - 1'b1;
      case (ctl.op)
        OP_TICK: begin
          now_r <= now_r + 1'b1;
          n_r   <= '0;
        end
        OP_ADD_SETUP: begin
          next_id_r <= gen_id;
          k_r       <= cnt_r;
          done_r    <= 1'b0;
        end
        OP_INS_STEP: begin
          if (push_en)     done_r <= 1'b1;
          else if (rot_en) k_r    <= k_r - 1'b1;
        end
        OP_SRCH_SETUP: begin
          k_r     <= cnt_r;
          found_r <= 1'b0;
        end
        OP_SRCH_STEP: begin
          k_r <= k_r - 1'b1;
          if (match) found_r <= 1'b1;
        end
        OP_EXP_POP: begin
          n_r    <= n_r + 1'b1;
          k_r    <= cnt_r - 1'b1;
          done_r <= 1'b0;
        end
        default: ;
      endcase
      if (ctl.out_load)               out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LOAD: begin
        cmd_r   <= in_cmd;
        delay_r <= in_delay_ms;
        tid_r   <= in_tid;
      end
      OP_ADD_SETUP: begin
        new_trig_r <= now_r + TIME_W'(delay_r);
        new_per_r  <= (cmd_r == CMD_ADD_PER) ? delay_r : '0;
        new_id_r   <= gen_id;
      end
      OP_SRCH_STEP: begin
        if (match) rem_r <= head_rem;
      end
      OP_EXP_POP: begin
        new_trig_r <= trig_r[0] + TIME_W'(per_r[0]);
        new_per_r  <= per_r[0];
        new_id_r   <= ids_r[0];
        pend_id_r  <= ids_r[0];
      end
      default: ;
    endcase
    if (ctl.out_load) begin
      out_kind_r <= ctl.out_kind;
      out_last_r <= ctl.out_last;
      out_rem_r  <= (ctl.out_kind == K_REMAINING) ? rem_r : '0;
      case (ctl.out_kind)
        K_ADDED:   out_id_r <= new_id_r;
        K_EXPIRED: out_id_r <= pend_id_r;
        K_FULL:    out_id_r <= '0;
        default:   out_id_r <= tid_r;
      endcase
    end
  end

  assign sts.cmd         = cmd_r;
  assign sts.full        = (cnt_r == CNT_W'(DEPTH));
  assign sts.exp_more    = (cnt_r != '0) && (n_r < RES_W'(MAX_RES)) && head_due;
  assign sts.n_zero      = (n_r == '0);
  assign sts.head_per_nz = (per_r[0] != '0);
  assign sts.ins_done    = done_r && (k_r == '0);
  assign sts.srch_done   = (k_r == '0);
  assign sts.found       = found_r;
  assign sts.out_busy    = out_valid_r;

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_result_id    = out_id_r;
  assign out_remaining_ms = out_rem_r;
  assign out_last         = out_last_r;

endmodule
